FILE: src/quadrature_speed_estimator_assert.svh
// assertion helpers for the checker file
`ifndef QUADRATURE_SPEED_ESTIMATOR_ASSERT_SVH
`define QUADRATURE_SPEED_ESTIMATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define QSE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quadrature speed estimator: same-cycle check failed");

// next-cycle implication, disabled during reset
`define QSE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quadrature speed estimator: next-cycle check failed");

`endif

FILE: src/qse_pkg.sv
package qse_pkg;

  // configuration port geometry
  localparam int ADDR_W = 3;
  localparam logic REG_COUNT_SCALE = 1'b0;

  // arithmetic constants, all positive and 21-bit signed friendly
  localparam logic [20:0] US_PER_S            = 21'd1000000;
  localparam logic [20:0] ALPHA_Q16           = 21'd19661;
  localparam logic [20:0] ONE_MINUS_ALPHA_Q16 = 21'd45875;
  localparam logic [53:0] ROUND_HALF          = 54'd32768;

  // divider: numerator is the 84-bit product shifted down by 16
  localparam int NUM_W = 68;
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] DIV_LAST_IDX = CNT_W'(NUM_W - 1);

  // request codes
  localparam logic REQ_PIN  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic        enc_a_level;
    logic        enc_b_level;
    logic [15:0] period_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_count;
    logic signed [31:0] velocity_q16;
    logic               velocity_updated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_SAT,
    ST_FILT_A,
    ST_FILT_B,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_P,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_DIV,
    OP_SAT,
    OP_FILT_A,
    OP_FILT_B,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slow_item;
    logic div_last;
  } dp_status_t;

endpackage

FILE: src/qse_chan_if.sv
interface qse_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/qse_apb_regs.sv
module qse_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qse_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 count_scale_o
);

  logic [31:0] count_scale_q, count_scale_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    count_scale_d = count_scale_q;
    if (wr_en && (paddr[qse_pkg::ADDR_W-1] == qse_pkg::REG_COUNT_SCALE)) begin
      count_scale_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_scale_q <= '0;
    end else begin
      count_scale_q <= count_scale_d;
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[qse_pkg::ADDR_W-1])
      qse_pkg::REG_COUNT_SCALE: prdata = count_scale_q;
      default:                  prdata = '0;
    endcase
  end

  assign count_scale_o = count_scale_q;

endmodule

FILE: src/qse_ctrl.sv
module qse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  qse_pkg::dp_status_t status_i,
  output qse_pkg::ctrl_cmd_t  cmd_o
);

  qse_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            fast_load;

  // take an item only when idle and the output slot is free or draining
  assign in_ready_o  = (state_q == qse_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign fast_load   = accept && !status_i.slow_item;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qse_pkg::ST_IDLE:   if (accept && status_i.slow_item) begin
        state_d = qse_pkg::ST_MUL_P;
      end
      qse_pkg::ST_MUL_P:  state_d = qse_pkg::ST_MUL_LO;
      qse_pkg::ST_MUL_LO: state_d = qse_pkg::ST_MUL_HI;
      qse_pkg::ST_MUL_HI: state_d = qse_pkg::ST_DIV;
      qse_pkg::ST_DIV:    if (status_i.div_last) begin
        state_d = qse_pkg::ST_SAT;
      end
      qse_pkg::ST_SAT:    state_d = qse_pkg::ST_FILT_A;
      qse_pkg::ST_FILT_A: state_d = qse_pkg::ST_FILT_B;
      qse_pkg::ST_FILT_B: state_d = qse_pkg::ST_FINISH;
      qse_pkg::ST_FINISH: state_d = qse_pkg::ST_IDLE;
      default:            state_d = qse_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.accept = accept;
    unique case (state_q)
      qse_pkg::ST_MUL_P:  cmd_o.op = qse_pkg::OP_MUL_P;
      qse_pkg::ST_MUL_LO: cmd_o.op = qse_pkg::OP_MUL_LO;
      qse_pkg::ST_MUL_HI: cmd_o.op = qse_pkg::OP_MUL_HI;
      qse_pkg::ST_DIV:    cmd_o.op = qse_pkg::OP_DIV;
      qse_pkg::ST_SAT:    cmd_o.op = qse_pkg::OP_SAT;
      qse_pkg::ST_FILT_A: cmd_o.op = qse_pkg::OP_FILT_A;
      qse_pkg::ST_FILT_B: cmd_o.op = qse_pkg::OP_FILT_B;
      qse_pkg::ST_FINISH: cmd_o.op = qse_pkg::OP_FINISH;
      default:            cmd_o.op = qse_pkg::OP_NONE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (fast_load || (state_q == qse_pkg::ST_FINISH)) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qse_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/qse_datapath.sv
module qse_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qse_pkg::ctrl_cmd_t  cmd_i,
  output qse_pkg::dp_status_t status_o,
  input  qse_pkg::in_item_t   in_data_i,
  input  logic [31:0]         count_scale_i,
  output qse_pkg::out_item_t  out_data_o
);

  localparam int NW = qse_pkg::NUM_W;

  // architectural state
  logic [31:0]        edge_q, edge_d;
  logic [31:0]        last_tick_q, last_tick_d;
  logic               last_a_q, last_a_d;
  logic               primed_q, primed_d;
  logic signed [31:0] filt_q, filt_d;

  // working registers of a velocity update
  logic                   neg_q;
  logic [31:0]            magd_q;
  logic [15:0]            period_q;
  logic [63:0]            prod_q;
  logic signed [53:0]     acc_q;
  logic [NW-1:0]          num_q;
  logic [15:0]            rem_q;
  logic [qse_pkg::CNT_W-1:0] cnt_q;
  logic signed [32:0]     raw_q;
  qse_pkg::out_item_t     out_q;

  logic               is_tick;
  logic               fast_load;
  logic               slow_start;
  logic [31:0]        delta;
  logic signed [32:0] mb_a;
  logic signed [20:0] mb_b;
  logic signed [53:0] mb_p;
  logic [83:0]        x_sum;
  logic [16:0]        trial;
  logic               ge;
  logic [16:0]        trial_diff;
  logic [31:0]        lim;
  logic               over;
  logic [31:0]        mag;
  logic [37:0]        sh;
  logic signed [31:0] vel_new;

  assign is_tick    = (in_data_i.req_type == qse_pkg::REQ_TICK);
  assign status_o.slow_item = is_tick && (in_data_i.period_us != 16'd0);
  assign status_o.div_last  = (cnt_q == '0);
  assign fast_load  = cmd_i.accept && !status_o.slow_item;
  assign slow_start = cmd_i.accept && status_o.slow_item;
  assign delta      = edge_q - last_tick_q;

  // quadrature decode and tick baseline
  always_comb begin
    edge_d      = edge_q;
    last_tick_d = last_tick_q;
    last_a_d    = last_a_q;
    primed_d    = primed_q;
    if (cmd_i.accept) begin
      if (is_tick) begin
        last_tick_d = edge_q;
      end else if (!primed_q) begin
        last_a_d = in_data_i.enc_a_level;
        primed_d = 1'b1;
      end else if (in_data_i.enc_a_level != last_a_q) begin
        last_a_d = in_data_i.enc_a_level;
        if (in_data_i.enc_a_level != in_data_i.enc_b_level) begin
          edge_d = edge_q + 32'd1;
        end else begin
          edge_d = edge_q - 32'd1;
        end
      end
    end
  end

  // shared signed multiplier, operands chosen by step
  always_comb begin
    unique case (cmd_i.op)
      qse_pkg::OP_MUL_HI: begin
        mb_a = $signed({1'b0, prod_q[63:32]});
        mb_b = $signed(qse_pkg::US_PER_S);
      end
      qse_pkg::OP_FILT_A: begin
        mb_a = raw_q;
        mb_b = $signed(qse_pkg::ALPHA_Q16);
      end
      qse_pkg::OP_FILT_B: begin
        mb_a = $signed({filt_q[31], filt_q});
        mb_b = $signed(qse_pkg::ONE_MINUS_ALPHA_Q16);
      end
      default: begin
        mb_a = $signed({1'b0, prod_q[31:0]});
        mb_b = $signed(qse_pkg::US_PER_S);
      end
    endcase
  end

  assign mb_p = mb_a * mb_b;

  // full product assembly, low partial held in acc
  assign x_sum = {mb_p[51:0], 32'd0} + {32'd0, acc_q[51:0]};

  // restoring divider step
  assign trial      = {rem_q, num_q[NW-1]};
  assign ge         = (trial >= {1'b0, period_q});
  assign trial_diff = trial - {1'b0, period_q};

  // magnitude saturation
  assign lim  = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign over = (|num_q[NW-1:32]) || (num_q[31:0] > lim);
  assign mag  = over ? lim : num_q[31:0];

  // floor shift of the blended sum and clamp
  assign sh = acc_q[53:16];
  always_comb begin
    if (!sh[37] && (|sh[36:31])) begin
      vel_new = 32'sh7FFF_FFFF;
    end else if (sh[37] && !(&sh[36:31])) begin
      vel_new = 32'sh8000_0000;
    end else begin
      vel_new = $signed(sh[31:0]);
    end
  end

  assign filt_d = (cmd_i.op == qse_pkg::OP_FINISH) ? vel_new : filt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q      <= '0;
      last_tick_q <= '0;
      last_a_q    <= 1'b0;
      primed_q    <= 1'b0;
      filt_q      <= '0;
    end else begin
      edge_q      <= edge_d;
      last_tick_q <= last_tick_d;
      last_a_q    <= last_a_d;
      primed_q    <= primed_d;
      filt_q      <= filt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (slow_start) begin
      neg_q    <= delta[31];
      magd_q   <= delta[31] ? (32'd0 - delta) : delta;
      period_q <= in_data_i.period_us;
    end
    unique case (cmd_i.op)
      qse_pkg::OP_MUL_P: begin
        prod_q <= magd_q * count_scale_i;
      end
      qse_pkg::OP_MUL_LO: begin
        acc_q <= mb_p;
      end
      qse_pkg::OP_MUL_HI: begin
        num_q <= x_sum[83:16];
        rem_q <= '0;
        cnt_q <= qse_pkg::DIV_LAST_IDX;
      end
      qse_pkg::OP_DIV: begin
        num_q <= {num_q[NW-2:0], ge};
        rem_q <= ge ? trial_diff[15:0] : trial[15:0];
        cnt_q <= cnt_q - 1'b1;
      end
      qse_pkg::OP_SAT: begin
        raw_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      qse_pkg::OP_FILT_A: begin
        acc_q <= mb_p + $signed(qse_pkg::ROUND_HALF);
      end
      qse_pkg::OP_FILT_B: begin
        acc_q <= acc_q + mb_p;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fast_load) begin
      out_q.position_count   <= $signed(edge_d);
      out_q.velocity_q16     <= filt_q;
      out_q.velocity_updated <= 1'b0;
    end else if (cmd_i.op == qse_pkg::OP_FINISH) begin
      out_q.position_count   <= $signed(edge_q);
      out_q.velocity_q16     <= vel_new;
      out_q.velocity_updated <= 1'b1;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: src/quadrature_speed_estimator.sv
// channel      | role   | handshake      | payload
// in_chan_i    | sink   | valid / ready  | req_type, enc_a_level, enc_b_level, period_us
// out_chan_o   | source | valid / ready  | position_count, velocity_q16, velocity_updated
// apb          | slave  | psel / penable | count_scale at byte address 0
//
// pin samples and zero-period ticks are done on acceptance; the result shows the next cycle
// other ticks run the 32x32 multiply, then the 68-step bit-serial divider,
// then the shared multiplier steps of the filter
// reset clears count, tick baseline, filter and priming; no clearing pass
// input stalls while a result waits untaken or a tick is being worked on
module quadrature_speed_estimator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  qse_chan_if.sink                   in_chan_i,
  qse_chan_if.source                 out_chan_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qse_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic                count_scale;
  logic [31:0]         count_scale_w;
  qse_pkg::ctrl_cmd_t  cmd;
  qse_pkg::dp_status_t status;
  qse_pkg::in_item_t   in_data;
  qse_pkg::out_item_t  out_data;
  logic                in_ready;
  logic                out_valid;

  assign count_scale = |count_scale_w;
  assign in_data     = in_chan_i.data;

  // configuration registers
  qse_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .count_scale_o (count_scale_w)
  );

  // sequencing
  qse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_chan_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // decode, scaling, division and filter
  qse_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_data_i     (in_data),
    .count_scale_i (count_scale ? count_scale_w : 32'd0),
    .out_data_o    (out_data)
  );

  assign in_chan_i.ready  = in_ready;
  assign out_chan_o.valid = out_valid;
  assign out_chan_o.data  = out_data;

endmodule

FILE: src/qse_checker.sv
`include "quadrature_speed_estimator_assert.svh"

module qse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input qse_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input qse_pkg::out_item_t out_data
);

  logic in_xfer;
  logic fast_item;
  logic slow_item;

  assign in_xfer   = in_valid && in_ready;
  assign fast_item = (in_data.req_type == qse_pkg::REQ_PIN) || (in_data.period_us == 16'd0);
  assign slow_item = !fast_item;

  // a pin sample or zero-period tick yields its result on the next cycle
  `QSE_ASSERT_NEXT(a_fast_latency, clk_i, rst_ni, in_xfer && fast_item, out_valid)

  // a velocity update keeps the output empty right after acceptance
  `QSE_ASSERT_NEXT(a_slow_empty, clk_i, rst_ni, in_xfer && slow_item, !out_valid)

  // no input transfer while a result waits untaken
  `QSE_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, out_valid && !out_ready, !in_ready)

  // a stalled result holds its payload
  `QSE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready,
                   out_valid && $stable(out_data))

endmodule

bind quadrature_speed_estimator qse_checker u_qse_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_chan_i.valid),
  .in_ready  (in_chan_i.ready),
  .in_data   (in_chan_i.data),
  .out_valid (out_chan_o.valid),
  .out_ready (out_chan_o.ready),
  .out_data  (out_chan_o.data)
);
